@@ design/sep_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time ROM builders for the SABR path step core.
// No dependencies; every other file of the block but sep_ram imports this package.
package sep_pkg;

   localparam int PATH_W        = 10;
   localparam int NUM_PATHS_DEF = 1024;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;

   // 0.0001 in Q8.24.
   localparam logic [31:0] FLOOR_Q24 = 32'd1678;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CORR         = 3'd0,
      CSR_AUX_CORR     = 3'd1,
      CSR_EXPONENT     = 3'd2,
      CSR_VOLVOL       = 3'd3,
      CSR_INIT_FORWARD = 3'd4,
      CSR_INIT_VOL     = 3'd5
   } csr_index_type;

   localparam logic [15:0] CORR_RST         = 16'd0;
   localparam logic [15:0] AUX_CORR_RST     = 16'd32767;
   localparam logic [15:0] EXPONENT_RST     = 16'd16384;
   localparam logic [15:0] VOLVOL_RST       = 16'd1638;
   localparam logic [31:0] INIT_FORWARD_RST = 32'd16777216;
   localparam logic [31:0] INIT_VOL_RST     = 32'd3355443;

   // 65-entry interpolation tables.
   typedef logic [64:0][31:0] rom_type;

   typedef struct packed {
      logic [31:0] value;
      logic        floored;
   } settled_type;

   // Fields that ride along the back half of the pipeline.
   typedef struct packed {
      logic [PATH_W-1:0] path;
      logic [31:0]       forward;
      logic [31:0]       vol;
      logic              noise_neg;
      logic [31:0]       noise_mag;
      logic [31:0]       new_vol;
      logic              vol_floored;
   } carry_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] xv;
      logic [63:0] r;
      logic [63:0] bit_v;
      xv    = x;
      r     = 64'd0;
      bit_v = 64'h4000_0000_0000_0000;
      while (bit_v > xv) bit_v = bit_v >> 2;
      while (bit_v != 64'd0) begin
         if (xv >= r + bit_v) begin
            xv = xv - (r + bit_v);
            r  = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   // log2(1 + i/64) in Q0.30, built by repeated squaring.
   function automatic rom_type build_log_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] y;
      for (int i = 0; i < 64; i++) begin
         x = (64'd1 << 30) + (64'(i) << 24);
         y = 64'd0;
         for (int k = 0; k < 30; k++) begin
            x = (x * x) >> 30;
            y = y << 1;
            if (x >= (64'd2 << 30)) begin
               y = y | 64'd1;
               x = x >> 1;
            end
         end
         rom[i] = y[31:0];
      end
      rom[64] = 32'd1 << 30;
      return rom;
   endfunction

   // 2^(i/64) in Q1.30 as a rounded product of the roots 2^(2^-k).
   function automatic rom_type build_exp_rom();
      rom_type     rom;
      logic [63:0] root [1:6];
      logic [63:0] v;
      root[1] = isqrt64(64'd1 << 61);
      for (int k = 2; k <= 6; k++) root[k] = isqrt64(root[k-1] << 30);
      for (int i = 0; i < 64; i++) begin
         v = 64'd1 << 30;
         for (int k = 1; k <= 6; k++) begin
            if (((i >> (6 - k)) & 1) != 0) v = (v * root[k] + (64'd1 << 29)) >> 30;
         end
         rom[i] = v[31:0];
      end
      rom[64] = 32'd1 << 31;
      return rom;
   endfunction

   // Floors a negative result, saturates above the top of Q8.24.
   function automatic settled_type settle(input logic [47:0] v);
      settled_type s;
      if (v[47]) begin
         s.value   = FLOOR_Q24;
         s.floored = 1'b1;
      end else if (|v[46:32]) begin
         s.value   = 32'hFFFF_FFFF;
         s.floored = 1'b0;
      end else begin
         s.value   = v[31:0];
         s.floored = 1'b0;
      end
      return s;
   endfunction

endpackage

@@ design/sep_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sep_power.sv @@
`timescale 1ns / 1ps
// Pipelined forward^beta as exp2(beta * log2 F) with table interpolation.
// Depends on sep_pkg for the log and exp tables; six register stages.
module sep_power (
   input  logic        clock,
   input  logic [7:2]  stage_ld,
   input  logic [31:0] forward,
   input  logic [15:0] exponent,
   output logic [31:0] power
);
   import sep_pkg::*;

   localparam rom_type LOG_ROM = build_log_rom();
   localparam rom_type EXP_ROM = build_exp_rom();

   // Normalize.
   logic [4:0]  msb_c;
   logic [31:0] mant_c;
   always_comb begin
      msb_c = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (forward[i]) msb_c = 5'(i);
      end
      mant_c = forward << (5'd31 - msb_c);
   end

   logic        s2_zero_ff;
   logic [4:0]  s2_msb_ff;
   logic [5:0]  s2_idx_ff;
   logic [24:0] s2_rem_ff;

   // Log table interpolation.
   logic [31:0] lg_base_c;
   logic [31:0] lg_next_c;
   logic [24:0] lg_diff_c;
   logic [49:0] lg_prod_c;
   assign lg_base_c = LOG_ROM[{1'b0, s2_idx_ff}];
   assign lg_next_c = LOG_ROM[7'({1'b0, s2_idx_ff}) + 7'd1];
   assign lg_diff_c = 25'(lg_next_c - lg_base_c);
   assign lg_prod_c = lg_diff_c * s2_rem_ff;

   logic        s3_zero_ff;
   logic [4:0]  s3_msb_ff;
   logic [29:0] s3_base_ff;
   logic [24:0] s3_delta_ff;

   logic [29:0]        lg_c;
   logic [5:0]         exp2_c;
   logic signed [35:0] lf_c;
   assign lg_c   = s3_base_ff + 30'(s3_delta_ff);
   assign exp2_c = 6'(s3_msb_ff) - 6'd24;
   assign lf_c   = {exp2_c, lg_c};

   logic               s4_zero_ff;
   logic signed [35:0] s4_lf_ff;

   logic signed [52:0] y_c;
   assign y_c = s4_lf_ff * $signed({1'b0, exponent});

   logic               s5_zero_ff;
   logic signed [52:0] s5_y_ff;

   // Bias to a positive value, round to Q.30, split integer and fraction.
   logic [52:0] u_c;
   logic [37:0] us_c;
   logic [31:0] ex_base_c;
   logic [31:0] ex_next_c;
   logic [24:0] ex_diff_c;
   logic [48:0] ex_prod_c;
   assign u_c       = 53'(s5_y_ff) + (53'd1 << 51) + (53'd1 << 14);
   assign us_c      = u_c[52:15];
   assign ex_base_c = EXP_ROM[{1'b0, us_c[29:24]}];
   assign ex_next_c = EXP_ROM[7'({1'b0, us_c[29:24]}) + 7'd1];
   assign ex_diff_c = 25'(ex_next_c - ex_base_c);
   assign ex_prod_c = ex_diff_c * us_c[23:0];

   logic        s6_zero_ff;
   logic [6:0]  s6_hi_ff;
   logic [31:0] s6_base_ff;
   logic [24:0] s6_delta_ff;

   // Integer part 64 stands for 2^0; the mantissa sits at Q.30, the result at Q.24.
   logic [31:0] x_c;
   logic [32:0] xs_c;
   logic [5:0]  sh_c;
   logic [71:0] z_c;
   logic [31:0] pw_c;
   always_comb begin
      x_c  = s6_base_ff + 32'(s6_delta_ff);
      xs_c = {1'b0, x_c} << (s6_hi_ff - 7'd70);
      sh_c = 6'(7'd70 - s6_hi_ff);
      z_c  = {x_c, 40'd0} >> sh_c;
      priority if (s6_zero_ff) begin
         pw_c = (exponent == 16'd0) ? (32'd1 << 24) : 32'd0;
      end else if (s6_hi_ff >= 7'd72) begin
         pw_c = 32'hFFFF_FFFF;
      end else if (s6_hi_ff >= 7'd70) begin
         pw_c = xs_c[32] ? 32'hFFFF_FFFF : xs_c[31:0];
      end else if (s6_hi_ff <= 7'd30) begin
         pw_c = 32'd0;
      end else begin
         pw_c = z_c[71:40] + 32'(z_c[39]);
      end
   end

   logic [31:0] power_ff;

   always_ff @(posedge clock) begin
      if (stage_ld[2]) begin
         s2_zero_ff <= (forward == 32'd0);
         s2_msb_ff  <= msb_c;
         s2_idx_ff  <= mant_c[30:25];
         s2_rem_ff  <= mant_c[24:0];
      end
      if (stage_ld[3]) begin
         s3_zero_ff  <= s2_zero_ff;
         s3_msb_ff   <= s2_msb_ff;
         s3_base_ff  <= lg_base_c[29:0];
         s3_delta_ff <= lg_prod_c[49:25];
      end
      if (stage_ld[4]) begin
         s4_zero_ff <= s3_zero_ff;
         s4_lf_ff   <= lf_c;
      end
      if (stage_ld[5]) begin
         s5_zero_ff <= s4_zero_ff;
         s5_y_ff    <= y_c;
      end
      if (stage_ld[6]) begin
         s6_zero_ff  <= s5_zero_ff;
         s6_hi_ff    <= us_c[36:30];
         s6_base_ff  <= ex_base_c;
         s6_delta_ff <= ex_prod_c[48:24];
      end
      if (stage_ld[7]) begin
         power_ff <= pw_c;
      end
   end

   assign power = power_ff;

endmodule

@@ design/sabr_euler_path_step_core.sv @@
`timescale 1ns / 1ps
// Top level of the SABR Euler path step core: control, stores and price/vol datapath.
// Depends on sep_pkg, sep_ram and sep_power.
//
// Usage:
//   Request beats carry a path index, a restart bit and two Q4.12 normal samples. Each
//   beat produces exactly one response beat with the path index, the new forward and vol
//   (Q8.24) and the two floor flags, in request order.
//   The datapath is a ten-stage pipeline behind one output register, and one beat can be
//   taken every cycle while req_stall is low.
//   Per-path forward and vol live in two RAMs; the read is issued as the beat is taken and
//   the write happens as the result enters the output register. A beat that is not a
//   restart and names a path still in flight is held off with req_stall until that path
//   has been written back. When rsp_stall is high on a valid response the output register
//   holds; stages behind it keep filling bubbles, and req_stall rises only once the stage
//   that takes new beats is full. Reset empties the pipeline and loads the default
//   register values. The path stores are not cleared: a path must see a restart beat
//   before it is stepped. Configuration registers are written through the csr_ port; the
//   user must do so only while no beat is in flight, which the block does not enforce.
module sabr_euler_path_step_core #(
   parameter int NUM_PATHS = sep_pkg::NUM_PATHS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sep_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sep_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sep_pkg::PATH_W-1:0]      req_path_index,
   input  logic                            req_restart,
   input  logic signed [15:0]              req_normal_price,
   input  logic signed [15:0]              req_normal_vol,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sep_pkg::PATH_W-1:0]      rsp_path_out,
   output logic [31:0]                     rsp_forward_out,
   output logic [31:0]                     rsp_vol_out,
   output logic                            rsp_forward_floored,
   output logic                            rsp_vol_floored
);
   import sep_pkg::*;

   localparam int ADDR_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
   localparam int LAST   = 10;

   // Configuration registers.
   logic signed [15:0] corr_ff;
   logic signed [15:0] aux_corr_ff;
   logic [15:0]        exponent_ff;
   logic [15:0]        volvol_ff;
   logic [31:0]        init_forward_ff;
   logic [31:0]        init_vol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corr_ff         <= CORR_RST;
         aux_corr_ff     <= AUX_CORR_RST;
         exponent_ff     <= EXPONENT_RST;
         volvol_ff       <= VOLVOL_RST;
         init_forward_ff <= INIT_FORWARD_RST;
         init_vol_ff     <= INIT_VOL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CORR:         corr_ff         <= csr_wr_data[15:0];
            CSR_AUX_CORR:     aux_corr_ff     <= csr_wr_data[15:0];
            CSR_EXPONENT:     exponent_ff     <= csr_wr_data[15:0];
            CSR_VOLVOL:       volvol_ff       <= csr_wr_data[15:0];
            CSR_INIT_FORWARD: init_forward_ff <= csr_wr_data;
            CSR_INIT_VOL:     init_vol_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Store address: path index modulo the number of paths.
   logic [ADDR_W-1:0] req_addr;
   generate
      if (NUM_PATHS >= 1024) begin : g_addr_direct
         assign req_addr = ADDR_W'(req_path_index);
      end else begin : g_addr_mod
         localparam int RECIP = ((1 << 20) + NUM_PATHS - 1) / NUM_PATHS;
         logic [30:0] q_prod;
         logic [19:0] qn;
         logic [19:0] rem;
         assign q_prod = req_path_index * 21'(RECIP);
         assign qn     = q_prod[29:20] * 10'(NUM_PATHS);
         assign rem    = 20'(req_path_index) - qn;
         assign req_addr = rem[ADDR_W-1:0];
      end
   endgenerate

   // Pipeline control: a stage loads when it is empty or the stage after it loads.
   logic [LAST:1]     vld_ff;
   logic [LAST:1]     vld_in;
   logic [LAST+1:1]   ld;
   logic [ADDR_W-1:0] addr_ff [1:LAST];
   logic              hazard;
   logic              accept;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              store_we;

   always_comb begin
      ld[LAST+1] = !rsp_valid_ff || !rsp_stall;
      for (int k = LAST; k >= 1; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
      hazard = 1'b0;
      for (int k = 1; k <= LAST; k++) begin
         if (vld_ff[k] && (addr_ff[k] == req_addr)) hazard = 1'b1;
      end
      hazard    = hazard && !req_restart;
      req_stall = !ld[1] || hazard;
      accept    = req_valid && !req_stall;
      vld_in[1] = ld[1] ? accept : vld_ff[1];
      for (int k = 2; k <= LAST; k++) begin
         vld_in[k] = ld[k] ? vld_ff[k-1] : vld_ff[k];
      end
      rsp_valid_in = ld[LAST+1] ? vld_ff[LAST] : rsp_valid_ff;
      store_we     = vld_ff[LAST] && ld[LAST+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Path stores.
   logic [31:0] fwd_rd;
   logic [31:0] vol_rd;
   settled_type new_f_c;
   carry_type   carry_ff [4:LAST];

   sep_ram #(.WIDTH(32), .DEPTH(NUM_PATHS)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (addr_ff[LAST]),
      .wr_data (new_f_c.value),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (fwd_rd)
   );

   sep_ram #(.WIDTH(32), .DEPTH(NUM_PATHS)) u_vol_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (addr_ff[LAST]),
      .wr_data (carry_ff[LAST].new_vol),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (vol_rd)
   );

   // Stage 1: pick the previous values, start the vol and noise products.
   logic [PATH_W-1:0]  s1_path_ff;
   logic               s1_restart_ff;
   logic signed [15:0] s1_w1_ff;
   logic signed [15:0] s1_w2_ff;

   logic [31:0]        f1_c;
   logic [31:0]        v1_c;
   logic signed [16:0] w2x_c;
   logic [16:0]        w2mag_c;
   logic [32:0]        vmag_c;
   logic signed [31:0] pcorr_c;
   logic signed [31:0] paux_c;
   assign f1_c    = s1_restart_ff ? init_forward_ff : fwd_rd;
   assign v1_c    = s1_restart_ff ? init_vol_ff : vol_rd;
   assign w2x_c   = 17'(s1_w2_ff);
   assign w2mag_c = s1_w2_ff[15] ? 17'(-w2x_c) : 17'(w2x_c);
   assign vmag_c  = w2mag_c * volvol_ff;
   assign pcorr_c = s1_w2_ff * corr_ff;
   assign paux_c  = s1_w1_ff * aux_corr_ff;

   // Stage 2: noise sum and the vol increment product.
   logic [PATH_W-1:0]  s2_path_ff;
   logic [31:0]        s2_f_ff;
   logic [31:0]        s2_v_ff;
   logic [31:0]        s2_vmag_ff;
   logic signed [31:0] s2_pcorr_ff;
   logic signed [31:0] s2_paux_ff;
   logic               s2_w2neg_ff;

   logic signed [32:0] noise_c;
   logic [32:0]        noise_neg_c;
   logic [31:0]        nmag_c;
   logic [63:0]        dvp_c;
   assign noise_c     = 33'(s2_pcorr_ff) + 33'(s2_paux_ff);
   assign noise_neg_c = 33'(-noise_c);
   assign nmag_c      = noise_c[32] ? noise_neg_c[31:0] : noise_c[31:0];
   assign dvp_c       = s2_vmag_ff * s2_v_ff;

   // Stage 3: finish the new vol.
   logic [PATH_W-1:0] s3_path_ff;
   logic [31:0]       s3_f_ff;
   logic [31:0]       s3_v_ff;
   logic              s3_w2neg_ff;
   logic              s3_nneg_ff;
   logic [31:0]       s3_nmag_ff;
   logic [63:0]       s3_dvp_ff;

   logic [63:0] dv_sum_c;
   logic [39:0] dv_c;
   logic [47:0] nv_c;
   settled_type new_v_c;
   carry_type   carry3_c;
   always_comb begin
      dv_sum_c = s3_dvp_ff + (64'd1 << 23);
      dv_c     = dv_sum_c[63:24];
      nv_c     = s3_w2neg_ff ? (48'(s3_v_ff) - 48'(dv_c)) : (48'(s3_v_ff) + 48'(dv_c));
      new_v_c  = settle(nv_c);
      carry3_c.path        = s3_path_ff;
      carry3_c.forward     = s3_f_ff;
      carry3_c.vol         = s3_v_ff;
      carry3_c.noise_neg   = s3_nneg_ff;
      carry3_c.noise_mag   = s3_nmag_ff;
      carry3_c.new_vol     = new_v_c.value;
      carry3_c.vol_floored = new_v_c.floored;
   end

   // Stages 2 to 7 of the power unit run beside the carry fields.
   logic [31:0] pw;
   sep_power u_power (
      .clock    (clock),
      .stage_ld (ld[7:2]),
      .forward  (f1_c),
      .exponent (exponent_ff),
      .power    (pw)
   );

   // Stage 7: vol * F^beta.
   logic [63:0] tp_c;
   assign tp_c = carry_ff[7].vol * pw;

   // Stage 8: round to Q.24.
   logic [63:0] s8_tp_ff;
   logic [63:0] t_sum_c;
   logic [39:0] t_c;
   assign t_sum_c = s8_tp_ff + (64'd1 << 23);
   assign t_c     = t_sum_c[63:24];

   // Stage 9: noise times the diffusion term, split in two partial products.
   logic [39:0] s9_t_ff;
   logic [51:0] ph_c;
   logic [51:0] pl_c;
   assign ph_c = carry_ff[9].noise_mag * s9_t_ff[39:20];
   assign pl_c = carry_ff[9].noise_mag * s9_t_ff[19:0];

   // Stage 10: combine, round from Q.27 and settle the new forward.
   logic [51:0] s10_ph_ff;
   logic [51:0] s10_pl_ff;
   logic [72:0] d_sum_c;
   logic [45:0] d_c;
   logic [47:0] nf_c;
   always_comb begin
      d_sum_c = 73'({s10_ph_ff, 20'd0}) + 73'(s10_pl_ff) + (73'd1 << 26);
      d_c     = d_sum_c[72:27];
      nf_c    = carry_ff[LAST].noise_neg ? (48'(carry_ff[LAST].forward) - 48'(d_c))
                                         : (48'(carry_ff[LAST].forward) + 48'(d_c));
      new_f_c = settle(nf_c);
   end

   // Output register.
   logic [PATH_W-1:0] rsp_path_ff;
   logic [31:0]       rsp_forward_ff;
   logic [31:0]       rsp_vol_ff;
   logic              rsp_ffloor_ff;
   logic              rsp_vfloor_ff;

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         addr_ff[1]    <= req_addr;
         s1_path_ff    <= req_path_index;
         s1_restart_ff <= req_restart;
         s1_w1_ff      <= req_normal_price;
         s1_w2_ff      <= req_normal_vol;
      end
      for (int k = 2; k <= LAST; k++) begin
         if (ld[k]) addr_ff[k] <= addr_ff[k-1];
      end
      if (ld[2]) begin
         s2_path_ff  <= s1_path_ff;
         s2_f_ff     <= f1_c;
         s2_v_ff     <= v1_c;
         s2_vmag_ff  <= vmag_c[31:0];
         s2_pcorr_ff <= pcorr_c;
         s2_paux_ff  <= paux_c;
         s2_w2neg_ff <= s1_w2_ff[15];
      end
      if (ld[3]) begin
         s3_path_ff  <= s2_path_ff;
         s3_f_ff     <= s2_f_ff;
         s3_v_ff     <= s2_v_ff;
         s3_w2neg_ff <= s2_w2neg_ff;
         s3_nneg_ff  <= noise_c[32];
         s3_nmag_ff  <= nmag_c;
         s3_dvp_ff   <= dvp_c;
      end
      if (ld[4]) begin
         carry_ff[4] <= carry3_c;
      end
      for (int k = 5; k <= LAST; k++) begin
         if (ld[k]) carry_ff[k] <= carry_ff[k-1];
      end
      if (ld[8]) begin
         s8_tp_ff <= tp_c;
      end
      if (ld[9]) begin
         s9_t_ff <= t_c;
      end
      if (ld[10]) begin
         s10_ph_ff <= ph_c;
         s10_pl_ff <= pl_c;
      end
      if (ld[LAST+1]) begin
         rsp_path_ff    <= carry_ff[LAST].path;
         rsp_forward_ff <= new_f_c.value;
         rsp_vol_ff     <= carry_ff[LAST].new_vol;
         rsp_ffloor_ff  <= new_f_c.floored;
         rsp_vfloor_ff  <= carry_ff[LAST].vol_floored;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_path_out        = rsp_path_ff;
   assign rsp_forward_out     = rsp_forward_ff;
   assign rsp_vol_out         = rsp_vol_ff;
   assign rsp_forward_floored = rsp_ffloor_ff;
   assign rsp_vol_floored     = rsp_vfloor_ff;

endmodule

@@ tb/sabr_step_checker.sv @@
`timescale 1ns / 1ps
// Checker for the SABR path step core: watches the csr, request and response ports, predicts
// each response beat from its own copy of the path stores and registers, and compares fields.
// Depends on sep_pkg for the register index names, reset values, floor constant and widths.
module sabr_step_checker
   import sep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [PATH_W-1:0]      req_path_index,
   input  logic                   req_restart,
   input  logic signed [15:0]     req_normal_price,
   input  logic signed [15:0]     req_normal_vol,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [PATH_W-1:0]      rsp_path_out,
   input  logic [31:0]            rsp_forward_out,
   input  logic [31:0]            rsp_vol_out,
   input  logic                   rsp_forward_floored,
   input  logic                   rsp_vol_floored,
   output int                     errors,
   output int                     pending
);

   typedef struct {
      logic [PATH_W-1:0] path;
      logic [31:0]       forward;
      logic [31:0]       vol;
      logic              forward_floored;
      logic              vol_floored;
   } step_result_type;

   logic [63:0] log2_tab [0:64];
   logic [63:0] exp2_tab [0:64];
   logic [31:0] forward_mem [0:1023];
   logic [31:0] vol_mem [0:1023];

   logic signed [63:0] corr_q, aux_corr_q;
   logic [63:0]        beta_q, volvol_q, init_forward_q, init_vol_q;

   step_result_type expected_steps [$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = x;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   initial begin
      logic [63:0] x, y, v;
      logic [63:0] roots [1:6];
      for (int i = 0; i < 64; i++) begin
         x = (64'd1 << 30) + (64'(i) << 24);
         y = 0;
         for (int k = 0; k < 30; k++) begin
            x = (x * x) >> 30;
            y = y << 1;
            if (x >= (64'd2 << 30)) begin
               y = y | 64'd1;
               x = x >> 1;
            end
         end
         log2_tab[i] = y;
      end
      log2_tab[64] = 64'd1 << 30;
      roots[1] = int_sqrt(64'd1 << 61);
      for (int k = 2; k <= 6; k++) roots[k] = int_sqrt(roots[k-1] << 30);
      for (int i = 0; i < 64; i++) begin
         v = 64'd1 << 30;
         for (int k = 1; k <= 6; k++)
            if (((i >> (6 - k)) & 1) != 0) v = (v * roots[k] + (64'd1 << 29)) >> 30;
         exp2_tab[i] = v;
      end
      exp2_tab[64] = 64'd2 << 30;
   end

   // Exact product, rounded half up after the shift, saturating at 64 bits.
   function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p[127:64] != 0) return '1;
      return p[63:0];
   endfunction

   // F^beta in Q8.24 through log2, a multiply and exp2.
   function automatic logic [63:0] forward_pow(input logic [63:0] f, input logic [63:0] beta);
      int                 msb, ip, s;
      logic [63:0]        mant, frac, idx, rem, lg, u, x;
      logic signed [63:0] lf, y;
      if (f == 0) return (beta == 0) ? (64'd1 << 24) : 64'd0;
      msb = 31;
      while (!f[msb]) msb--;
      mant = f << (31 - msb);
      frac = mant - (64'd1 << 31);
      idx  = frac >> 25;
      rem  = frac & 64'h1FF_FFFF;
      lg   = log2_tab[idx] + (((log2_tab[idx+1] - log2_tab[idx]) * rem) >> 25);
      lf   = 64'(msb - 24) * 64'sd1073741824 + $signed(lg);
      y    = lf * $signed(beta);
      u    = y + (64'sd1 <<< 51);
      u    = (u + (64'd1 << 14)) >> 15;
      ip   = int'(u >> 30) - 64;
      frac = u & ((64'd1 << 30) - 1);
      idx  = frac >> 24;
      rem  = frac & 64'hFF_FFFF;
      x    = exp2_tab[idx] + (((exp2_tab[idx+1] - exp2_tab[idx]) * rem) >> 24);
      s    = ip - 6;
      if (s >= 2) return 64'hFFFF_FFFF;
      if (s >= 0) begin
         x = x << s;
         return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
      end
      if (-s >= 40) return 0;
      return (x + (64'd1 << (-s - 1))) >> (-s);
   endfunction

   function automatic logic [31:0] clamp_q24(input logic signed [63:0] v, output logic floored);
      floored = 1'b0;
      if (v < 0) begin
         floored = 1'b1;
         return FLOOR_Q24;
      end
      if (v > 64'sh FFFF_FFFF) return 32'hFFFF_FFFF;
      return v[31:0];
   endfunction

   function automatic step_result_type advance_path(input logic [PATH_W-1:0] path,
                                                    input logic restart,
                                                    input logic signed [15:0] w1,
                                                    input logic signed [15:0] w2);
      step_result_type    r;
      logic [63:0]        f, v, vmag, d, t, nmag;
      logic signed [63:0] noise, nv, nf, w1l, w2l;
      w1l   = w1;
      w2l   = w2;
      f     = restart ? init_forward_q : 64'(forward_mem[path]);
      v     = restart ? init_vol_q : 64'(vol_mem[path]);
      vmag  = 64'(w2l < 0 ? -w2l : w2l) * volvol_q;
      d     = mul_round(vmag, v, 24);
      nv    = (w2l < 0) ? $signed(v) - $signed(d) : $signed(v) + $signed(d);
      t     = mul_round(v, forward_pow(f, beta_q), 24);
      noise = w2l * corr_q + w1l * aux_corr_q;
      nmag  = 64'(noise < 0 ? -noise : noise);
      d     = mul_round(nmag, t, 27);
      if (d > (64'd1 << 50)) d = 64'd1 << 50;
      nf    = (noise < 0) ? $signed(f) - $signed(d) : $signed(f) + $signed(d);
      r.path    = path;
      r.vol     = clamp_q24(nv, r.vol_floored);
      r.forward = clamp_q24(nf, r.forward_floored);
      forward_mem[path] = r.forward;
      vol_mem[path]     = r.vol;
      return r;
   endfunction

   always @(posedge clock) begin
      step_result_type e;
      if (reset) begin
         corr_q         <= $signed(CORR_RST);
         aux_corr_q     <= $signed(AUX_CORR_RST);
         beta_q         <= 64'(EXPONENT_RST);
         volvol_q       <= 64'(VOLVOL_RST);
         init_forward_q <= 64'(INIT_FORWARD_RST);
         init_vol_q     <= 64'(INIT_VOL_RST);
         expected_steps.delete();
         pending = 0;
         errors  = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CORR:         corr_q         <= $signed(csr_wr_data[15:0]);
               CSR_AUX_CORR:     aux_corr_q     <= $signed(csr_wr_data[15:0]);
               CSR_EXPONENT:     beta_q         <= 64'(csr_wr_data[15:0]);
               CSR_VOLVOL:       volvol_q       <= 64'(csr_wr_data[15:0]);
               CSR_INIT_FORWARD: init_forward_q <= 64'(csr_wr_data);
               CSR_INIT_VOL:     init_vol_q     <= 64'(csr_wr_data);
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_steps.push_back(advance_path(req_path_index, req_restart,
                                                  req_normal_price, req_normal_vol));
         if (rsp_valid && !rsp_stall) begin
            if (expected_steps.size() == 0) begin
               $display("%0t: response beat with nothing expected, path %0d", $time,
                        rsp_path_out);
               errors++;
            end else begin
               e = expected_steps.pop_front();
               if (rsp_path_out !== e.path) begin
                  $display("%0t: path expected %0d actual %0d", $time, e.path, rsp_path_out);
                  errors++;
               end
               if (rsp_forward_out !== e.forward) begin
                  $display("%0t: forward expected %h actual %h (path %0d)", $time,
                           e.forward, rsp_forward_out, e.path);
                  errors++;
               end
               if (rsp_vol_out !== e.vol) begin
                  $display("%0t: vol expected %h actual %h (path %0d)", $time,
                           e.vol, rsp_vol_out, e.path);
                  errors++;
               end
               if (rsp_forward_floored !== e.forward_floored) begin
                  $display("%0t: forward floor flag expected %b actual %b (path %0d)", $time,
                           e.forward_floored, rsp_forward_floored, e.path);
                  errors++;
               end
               if (rsp_vol_floored !== e.vol_floored) begin
                  $display("%0t: vol floor flag expected %b actual %b (path %0d)", $time,
                           e.vol_floored, rsp_vol_floored, e.path);
                  errors++;
               end
            end
         end
         pending = expected_steps.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the SABR path step testbench: clock, reset, register phases and request beats.
// Depends on sep_pkg, sabr_euler_path_step_core and sabr_step_checker.
module testbench;
   import sep_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [PATH_W-1:0]      req_path_index;
   logic                   req_restart;
   logic signed [15:0]     req_normal_price;
   logic signed [15:0]     req_normal_vol;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PATH_W-1:0]      rsp_path_out;
   logic [31:0]            rsp_forward_out;
   logic [31:0]            rsp_vol_out;
   logic                   rsp_forward_floored;
   logic                   rsp_vol_floored;
   int                     errors;
   int                     pending;

   bit                     path_live [0:1023];
   bit                     idle_on;
   int                     rsp_hold;
   logic [PATH_W-1:0]      last_path;

   sabr_euler_path_step_core DUT (.*);
   sabr_step_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Response side: with idling on, a fresh stall length is drawn for every beat taken.
   always @(posedge clock) begin
      int wait_n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_stall <= (rsp_hold > 1);
      end else if (rsp_valid && !rsp_stall) begin
         wait_n    = idle_on ? int'($urandom_range(0, 16)) : 0;
         rsp_hold  <= wait_n;
         rsp_stall <= (wait_n > 0);
      end
   end

   task automatic send_beat(input logic [PATH_W-1:0] path, input logic restart,
                            input logic [15:0] w1, input logic [15:0] w2);
      int gap;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_path_index   <= path;
      req_restart      <= restart;
      req_normal_price <= w1;
      req_normal_vol   <= w2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (restart) path_live[path] = 1'b1;
      last_path = path;
   endtask

   // Holds off until every step in flight has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic write_all(input logic [15:0] c, input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] vv, input logic [31:0] f0,
                            input logic [31:0] v0);
      drain();
      write_reg(CSR_CORR, {16'd0, c});
      write_reg(CSR_AUX_CORR, {16'd0, a});
      write_reg(CSR_EXPONENT, {16'd0, b});
      write_reg(CSR_VOLVOL, {16'd0, vv});
      write_reg(CSR_INIT_FORWARD, f0);
      write_reg(CSR_INIT_VOL, v0);
   endtask

   function automatic logic [15:0] draw_normal();
      if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 8192)) - 16'd4096;
      return 16'($urandom);
   endfunction

   // Mostly continuing live paths with some restarts; some beats revisit the last path.
   task automatic random_beats(input int count);
      logic [PATH_W-1:0] p;
      logic              rs;
      for (int n = 0; n < count; n++) begin
         p  = ($urandom_range(0, 4) == 0) ? last_path : PATH_W'($urandom);
         rs = ($urandom_range(0, 9) == 0) || !path_live[p];
         send_beat(p, rs, draw_normal(), draw_normal());
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_path_index   = '0;
      req_restart      = 1'b0;
      req_normal_price = '0;
      req_normal_vol   = '0;
      idle_on          = 1'b0;
      last_path        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset register values.
      send_beat(10'd0, 1'b1, 16'h0000, 16'h0000);
      send_beat(10'd1023, 1'b1, 16'h7FFF, 16'h7FFF);
      send_beat(10'd0, 1'b0, 16'h8000, 16'h8000);
      send_beat(10'd1023, 1'b0, 16'h8000, 16'h7FFF);
      send_beat(10'd0, 1'b0, 16'h7FFF, 16'h8000);
      send_beat(10'd512, 1'b1, 16'hFFFF, 16'h0001);
      send_beat(10'd512, 1'b0, 16'h1000, 16'hF000);

      // Unit volvol and a vol sample of minus one give an exact zero vol.
      write_all(16'h8000, 16'h7FFF, 16'd16384, 16'd4096, 32'h0100_0000, 32'h0033_3333);
      send_beat(10'd5, 1'b1, 16'h0800, 16'hF000);
      send_beat(10'd5, 1'b0, 16'h0800, 16'h0400);

      // Zero forward with a zero and a nonzero beta.
      write_all(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF, 32'd0, 32'd1678);
      send_beat(10'd6, 1'b1, 16'h7FFF, 16'h7FFF);
      send_beat(10'd6, 1'b0, 16'h8000, 16'h8000);
      write_all(16'h4000, 16'h4000, 16'd200, 16'd0, 32'd0, 32'hFFFF_FFFF);
      send_beat(10'd7, 1'b1, 16'h7FFF, 16'h8000);
      send_beat(10'd7, 1'b0, 16'h8000, 16'h7FFF);

      // Beta above one on a large forward, saturating both ways.
      write_all(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(10'd8, 1'b1, 16'h7FFF, 16'h7FFF);
      send_beat(10'd9, 1'b1, 16'h8000, 16'h8000);
      send_beat(10'd8, 1'b0, 16'h1234, 16'hFEDC);

      // Random phases; the first has no idling on either side.
      write_all(16'h0000, 16'h7FFF, 16'd16384, 16'd1638, 32'h0100_0000, 32'h0033_3333);
      random_beats(140);
      idle_on = 1'b1;
      write_all(16'h8000, 16'h7FFF, 16'd0, 16'd4096, 32'd1678, 32'd1678);
      random_beats(140);
      write_all(16'h7FFF, 16'h8000, 16'd32768, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_beats(140);
      for (int ph = 0; ph < 3; ph++) begin
         idle_on = (ph != 1);
         write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32768)),
                   16'($urandom_range(0, 3000)), $urandom_range(32'h0080_0000, 32'h0400_0000),
                   $urandom_range(32'h0010_0000, 32'h0080_0000));
         random_beats(140);
      end

      drain();
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

@@ sabr_euler_path_step_core.f @@
design/sep_pkg.sv
design/sep_ram.sv
design/sep_power.sv
design/sabr_euler_path_step_core.sv
tb/sabr_step_checker.sv
tb/testbench.sv
